// File: rtl/core/wspd_pkg.sv
`default_nettype none

package wspd_pkg;

  localparam int unsigned WordW     = 16;
  localparam int unsigned HistDepth = 12;
  localparam int unsigned WinLen    = 8;
  localparam int unsigned WinIdxW   = 3;
  localparam int unsigned LenW      = 5;

  localparam logic [LenW-1:0] FullLength  = LenW'(20);
  localparam logic [LenW-1:0] StartLength = LenW'(8);

  localparam logic [WordW-1:0] Marker   = 16'h8000;
  localparam logic [WordW-1:0] StartMid = 16'h0001;
  localparam logic [WordW-1:0] AllOnes  = 16'hFFFF;
  localparam logic [WordW-1:0] K1HdrLo  = 16'h9000;
  localparam logic [WordW-1:0] K1HdrHi  = 16'h9FFF;
  localparam logic [WordW-1:0] K1SubLo  = 16'hA000;
  localparam logic [WordW-1:0] K1SubHi  = 16'hAFFF;
  localparam logic [WordW-1:0] K1TrlLo  = 16'hF000;
  localparam logic [WordW-1:0] K1TrlHi  = 16'hFFFF;
  localparam logic [WordW-1:0] K1EndLo  = 16'hE000;
  localparam logic [WordW-1:0] K1EndHi  = 16'hEFFF;

  // One queued command: either a single in-packet word (in words[0])
  // or a start burst of the eight window words.
  typedef struct packed {
    logic [WinLen-1:0][WordW-1:0] words;
    logic                         burst;
    logic                         kind;
    logic                         last;
    logic                         cut;
  } cmd_t;

endpackage

`default_nettype wire

// File: rtl/core/wspd_in_if.sv
`default_nettype none

interface wspd_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] data_word;
  logic        stream_end;

  modport source (output valid, output data_word, output stream_end, input ready);
  modport sink   (input valid, input data_word, input stream_end, output ready);
endinterface

`default_nettype wire

// File: rtl/core/wspd_out_if.sv
`default_nettype none

interface wspd_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_word;
  logic        first_word;
  logic        last_word;
  logic        packet_kind;
  logic        cut_short;

  modport source (output valid, output out_word, output first_word, output last_word,
                  output packet_kind, output cut_short, input ready);
  modport sink   (input valid, input out_word, input first_word, input last_word,
                  input packet_kind, input cut_short, output ready);
endinterface

`default_nettype wire

// File: rtl/core/word_stream_packet_delimiter.sv
// A word that yields output is written into the command queue, then loaded into the output
// register and presented on out_o once that register is empty or being taken.
// Throughput: one input transaction per cycle; a packet start yields eight results that drain
// one per cycle from the back end while out_o.ready is high, so input stalls once the command
// queue is full. Output rate is one result per cycle while out_o.ready is high, bounded by the single output register.
// Reset (rst_ni, async active low): search mode, window zeroed, queue and output empty.
`default_nettype none

module word_stream_packet_delimiter #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  wspd_in_if.sink   in_i,
  wspd_out_if.source out_o
);

  // front -> queue
  logic           push;
  wspd_pkg::cmd_t push_cmd;
  logic           full;

  // queue -> back
  logic           head_valid;
  wspd_pkg::cmd_t head_cmd;
  logic           pop;

  // Front: shifts words into the history, detects starts and trailers,
  // and emits one command per transaction that produces output.
  wspd_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .cmd_o  (push_cmd)
  );

  // Short command queue decoupling the classifier from the result sequencer.
  wspd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .cmd_i        (push_cmd),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head_cmd)
  );

  // Back: expands start bursts into eight results, passes single words,
  // and holds each result in an output register until taken.
  wspd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head_cmd),
    .pop_o        (pop),
    .out_o        (out_o)
  );

endmodule

`default_nettype wire

// File: rtl/core/wspd_front.sv
`default_nettype none

module wspd_front (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  wspd_in_if.sink           in_i,
  input  wire logic         full_i,
  output logic              push_o,
  output wspd_pkg::cmd_t    cmd_o
);

  localparam logic [1:0] ModeSearch = 2'd0;
  localparam logic [1:0] ModeKind0  = 2'd1;
  localparam logic [1:0] ModeKind1  = 2'd2;

  logic [wspd_pkg::HistDepth-1:0][wspd_pkg::WordW-1:0] hist_q, hist_d, sh;
  logic [1:0]                    mode_q, mode_d;
  logic [wspd_pkg::LenW-1:0]     len_q, len_d, len_inc;
  logic                          accept;
  logic                          in_pkt, kind_cur, done, k0_start, k1_start;

  function automatic logic in_range(input logic [15:0] v, input logic [15:0] lo,
                                    input logic [15:0] hi);
    in_range = (v >= lo) && (v <= hi);
  endfunction

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && !full_i;

  // newest word at the top; "k back" is sh[12-k]
  assign sh = {in_i.data_word, hist_q[wspd_pkg::HistDepth-1:1]};

  always_comb begin
    in_pkt   = (mode_q == ModeKind0) || (mode_q == ModeKind1);
    kind_cur = (mode_q == ModeKind1);
    len_inc  = (len_q < wspd_pkg::FullLength) ? len_q + 1'b1 : wspd_pkg::FullLength;

    if (kind_cur) begin
      // 8..5 back in the F range, 4..2 back in the E range
      done = in_range(sh[4],  wspd_pkg::K1TrlLo, wspd_pkg::K1TrlHi) &&
             in_range(sh[5],  wspd_pkg::K1TrlLo, wspd_pkg::K1TrlHi) &&
             in_range(sh[6],  wspd_pkg::K1TrlLo, wspd_pkg::K1TrlHi) &&
             in_range(sh[7],  wspd_pkg::K1TrlLo, wspd_pkg::K1TrlHi) &&
             in_range(sh[8],  wspd_pkg::K1EndLo, wspd_pkg::K1EndHi) &&
             in_range(sh[9],  wspd_pkg::K1EndLo, wspd_pkg::K1EndHi) &&
             in_range(sh[10], wspd_pkg::K1EndLo, wspd_pkg::K1EndHi);
    end else begin
      done = (len_inc == wspd_pkg::FullLength) &&
             (sh[0] == wspd_pkg::Marker) && (sh[1] == wspd_pkg::Marker) &&
             (sh[2] == wspd_pkg::AllOnes) && (sh[3] == wspd_pkg::Marker);
    end

    // window word i is sh[4+i]
    k0_start = (sh[9] == wspd_pkg::Marker) && (sh[10] == wspd_pkg::StartMid) &&
               (sh[11] == wspd_pkg::Marker);
    k1_start = in_range(sh[4],  wspd_pkg::K1HdrLo, wspd_pkg::K1HdrHi) &&
               in_range(sh[5],  wspd_pkg::K1HdrLo, wspd_pkg::K1HdrHi) &&
               in_range(sh[6],  wspd_pkg::K1HdrLo, wspd_pkg::K1HdrHi) &&
               in_range(sh[7],  wspd_pkg::K1HdrLo, wspd_pkg::K1HdrHi) &&
               in_range(sh[8],  wspd_pkg::K1SubLo, wspd_pkg::K1SubHi) &&
               in_range(sh[9],  wspd_pkg::K1SubLo, wspd_pkg::K1SubHi) &&
               in_range(sh[10], wspd_pkg::K1SubLo, wspd_pkg::K1SubHi);

    hist_d = hist_q;
    mode_d = mode_q;
    len_d  = len_q;
    push_o = 1'b0;
    cmd_o  = '0;

    if (in_pkt) begin
      cmd_o.words[0] = in_i.data_word;
      cmd_o.kind     = kind_cur;
      cmd_o.last     = done || in_i.stream_end;
      cmd_o.cut      = !done && in_i.stream_end;
      push_o         = accept;
      if (accept) begin
        if (done || in_i.stream_end) begin
          hist_d = '0;
          mode_d = ModeSearch;
          len_d  = '0;
        end else begin
          hist_d = sh;
          len_d  = len_inc;
        end
      end
    end else begin
      for (int i = 0; i < wspd_pkg::WinLen; i++) begin
        cmd_o.words[i] = sh[4+i];
      end
      cmd_o.burst = 1'b1;
      cmd_o.kind  = !k0_start;
      cmd_o.last  = in_i.stream_end;
      cmd_o.cut   = in_i.stream_end;
      push_o      = accept && (k0_start || k1_start);
      if (accept) begin
        if (in_i.stream_end) begin
          hist_d = '0;
          mode_d = ModeSearch;
          len_d  = '0;
        end else begin
          hist_d = sh;
          if (k0_start) begin
            mode_d = ModeKind0;
            len_d  = wspd_pkg::StartLength;
          end else if (k1_start) begin
            mode_d = ModeKind1;
            len_d  = wspd_pkg::StartLength;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q <= '0;
      mode_q <= ModeSearch;
      len_q  <= '0;
    end else begin
      hist_q <= hist_d;
      mode_q <= mode_d;
      len_q  <= len_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/wspd_queue.sv
`default_nettype none

module wspd_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire wspd_pkg::cmd_t  cmd_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output logic                 head_valid_o,
  output wspd_pkg::cmd_t       head_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  wspd_pkg::cmd_t  slot_q [DEPTH];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o       = (cnt_q == CntW'(DEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = slot_q[rd_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/wspd_back.sv
`default_nettype none

module wspd_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            head_valid_i,
  input  wire wspd_pkg::cmd_t  head_i,
  output logic                 pop_o,
  wspd_out_if.source           out_o
);

  logic [wspd_pkg::WinIdxW-1:0] idx_q, idx_d;
  logic                         ovalid_q, ovalid_d;
  logic [wspd_pkg::WordW-1:0]   word_q, word_d;
  logic                         first_q, first_d, last_q, last_d;
  logic                         kind_q, kind_d, cut_q, cut_d;
  logic                         load, tail;

  assign load = head_valid_i && (!ovalid_q || out_o.ready);
  assign tail = !head_i.burst || (idx_q == wspd_pkg::WinIdxW'(wspd_pkg::WinLen - 1));
  assign pop_o = load && tail;

  always_comb begin
    idx_d    = idx_q;
    ovalid_d = ovalid_q;
    word_d   = word_q;
    first_d  = first_q;
    last_d   = last_q;
    kind_d   = kind_q;
    cut_d    = cut_q;
    if (load) begin
      ovalid_d = 1'b1;
      word_d   = head_i.burst ? head_i.words[idx_q] : head_i.words[0];
      first_d  = head_i.burst && (idx_q == '0);
      last_d   = tail && head_i.last;
      cut_d    = tail && head_i.cut;
      kind_d   = head_i.kind;
      idx_d    = tail ? '0 : idx_q + 1'b1;
    end else if (out_o.ready) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      idx_q    <= idx_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q  <= word_d;
    first_q <= first_d;
    last_q  <= last_d;
    kind_q  <= kind_d;
    cut_q   <= cut_d;
  end

  assign out_o.valid       = ovalid_q;
  assign out_o.out_word    = word_q;
  assign out_o.first_word  = first_q;
  assign out_o.last_word   = last_q;
  assign out_o.packet_kind = kind_q;
  assign out_o.cut_short   = cut_q;

endmodule

`default_nettype wire

// File: sim/word_stream_packet_delimiter_test.sv
`default_nettype none

module word_stream_packet_delimiter_test;
  import wspd_pkg::*;

  // Stream length for the random part, not counting the directed opener.
  localparam int unsigned RandomWords = 340;
  // Cycles with no transaction on either side before the run is declared hung.
  localparam int unsigned IdleLimit   = 2000;
  // Settle time after the last expected word (two-stage pipe plus margin).
  localparam int unsigned DrainCycles = 12;

  typedef enum logic [1:0] {
    Searching,
    InKind0,
    InKind1
  } scan_mode_e;

  typedef struct packed {
    logic [WordW-1:0] word;
    logic             fin;
  } raw_word_t;

  typedef struct packed {
    logic [WordW-1:0] word;
    logic             first;
    logic             last;
    logic             kind;
    logic             cut;
  } pkt_word_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  wspd_in_if  in_if ();
  wspd_out_if out_if ();

  word_stream_packet_delimiter DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #5 clk_i = ~clk_i;

  // Raw words still to be offered, and packet words the block still owes us.
  raw_word_t raw_stream[$];
  pkt_word_t awaited_words[$];

  // Shadow of the delimiter: hist[HistDepth-1] is the newest word.
  logic [WordW-1:0] hist [HistDepth];
  scan_mode_e       scan_mode;
  logic [LenW-1:0]  pkt_len;

  int unsigned mismatches;
  int unsigned words_fed;
  int unsigned words_out;
  int unsigned packets_out;
  int unsigned cut_packets;
  int unsigned idle_cycles;

  // Sender burst/gap state and receiver stall pattern.
  int unsigned      gap_left;
  int unsigned      burst_left;
  logic [15:0]      stall_pat;
  int unsigned      pat_pos;
  int unsigned      pat_left;

  function automatic bit in_span(logic [WordW-1:0] v, logic [WordW-1:0] lo,
                                 logic [WordW-1:0] hi);
    return v >= lo && v <= hi;
  endfunction

  // Random word in [lo, hi], biased toward lo and hi.
  function automatic logic [WordW-1:0] span_word(logic [WordW-1:0] lo,
                                                 logic [WordW-1:0] hi);
    case ($urandom_range(0, 3))
      0: return lo;
      1: return hi;
      default: return WordW'($urandom_range(hi, lo));
    endcase
  endfunction

  function automatic void add_word(logic [WordW-1:0] w, logic fin);
    raw_word_t item;
    item = '{w, fin};
    raw_stream.insert(raw_stream.size(), item);
  endfunction

  // Append one packet word to the list the block owes.
  function automatic void owe_word(logic [WordW-1:0] w, logic first, logic last,
                                   logic kind, logic cut);
    pkt_word_t pw;
    pw = '{w, first, last, kind, cut};
    awaited_words.insert(awaited_words.size(), pw);
  endfunction

  function automatic void restart_search();
    foreach (hist[i]) hist[i] = '0;
    scan_mode = Searching;
    pkt_len   = '0;
  endfunction

  // Advance the shadow by one accepted raw word and queue the packet words it yields.
  function automatic void delimit_word(raw_word_t item);
    logic kind;
    logic done;
    logic k0;
    logic k1;
    for (int i = 0; i < HistDepth - 1; i++) hist[i] = hist[i+1];
    hist[HistDepth-1] = item.word;

    if (scan_mode == InKind0 || scan_mode == InKind1) begin
      kind = (scan_mode == InKind1);
      if (pkt_len < FullLength) pkt_len++;
      if (!kind) begin
        // long-header trailer: 12..9 back, only once the header is complete
        done = pkt_len >= FullLength && hist[0] == Marker && hist[1] == Marker &&
               hist[2] == AllOnes && hist[3] == Marker;
      end else begin
        // short-header trailer: 8..5 back in F range, 4..2 back in E range
        done = 1'b1;
        for (int i = 4; i < 8; i++) done &= in_span(hist[i], K1TrlLo, K1TrlHi);
        for (int i = 8; i < 11; i++) done &= in_span(hist[i], K1EndLo, K1EndHi);
      end
      owe_word(item.word, 1'b0, done || item.fin, kind, !done && item.fin);
      if (done || item.fin) restart_search();
    end else begin
      // window words 0..7 live in hist[4..11]
      k0 = hist[9] == Marker && hist[10] == StartMid && hist[11] == Marker;
      k1 = 1'b1;
      for (int i = 4; i < 8; i++) k1 &= in_span(hist[i], K1HdrLo, K1HdrHi);
      for (int i = 8; i < 11; i++) k1 &= in_span(hist[i], K1SubLo, K1SubHi);
      if (k0 || k1) begin
        for (int i = 0; i < WinLen; i++) begin
          owe_word(hist[HistDepth-WinLen+i], i == 0, i == WinLen - 1 && item.fin, !k0,
                   i == WinLen - 1 && item.fin);
        end
        if (item.fin) begin
          restart_search();
        end else begin
          scan_mode = k0 ? InKind0 : InKind1;
          pkt_len   = StartLength;
        end
      end else if (item.fin) begin
        restart_search();
      end
    end
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  // Sender: offers raw_stream[0], holds it until the transaction completes,
  // and runs in bursts separated by random gaps.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else begin : feed
      logic took;
      took = in_if.valid && in_if.ready;
      if (took) begin
        delimit_word(raw_stream.pop_front());
        words_fed++;
      end
      if (!in_if.valid || took) begin
        if (gap_left > 0 || raw_stream.size() == 0) begin
          in_if.valid <= 1'b0;
          if (gap_left > 0) gap_left--;
        end else begin
          in_if.valid      <= 1'b1;
          in_if.data_word  <= raw_stream[0].word;
          in_if.stream_end <= raw_stream[0].fin;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            // a zero gap now and then gives long stretches at full rate
            case ($urandom_range(0, 3))
              0: gap_left = 0;
              1, 2: gap_left = $urandom_range(1, 3);
              default: gap_left = $urandom_range(4, 12);
            endcase
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 16);
          end
        end
      end
    end
  end

  // Receiver: ready follows a rotating 16-bit pattern that is swapped out
  // whenever its random hold count runs out (always ready, random, sparse, or a long stall).
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= stall_pat[pat_pos];
      pat_pos = (pat_pos + 1) % 16;
      if (pat_left > 1) begin
        pat_left--;
      end else begin
        pat_left = $urandom_range(16, 96);
        case ($urandom_range(0, 3))
          0: stall_pat = '1;
          1: stall_pat = 16'($urandom) | 16'h0001;
          2: stall_pat = 16'($urandom & $urandom) | 16'h0100;
          default: stall_pat = 16'h00FF;
        endcase
      end
    end
  end

  // Output checker: every completed output transaction is matched against
  // the oldest word the shadow model expects.
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin : collect
      pkt_word_t want;
      if (awaited_words.size() == 0) begin
        mismatches++;
        $display("%0t: expected no packet word, actual word=%h first=%b last=%b kind=%b cut=%b",
                 $time, out_if.out_word, out_if.first_word, out_if.last_word,
                 out_if.packet_kind, out_if.cut_short);
      end else begin
        want = awaited_words.pop_front();
        check_field("out_word",    want.word,  out_if.out_word);
        check_field("first_word",  want.first, out_if.first_word);
        check_field("last_word",   want.last,  out_if.last_word);
        check_field("packet_kind", want.kind,  out_if.packet_kind);
        check_field("cut_short",   want.cut,   out_if.cut_short);
        words_out++;
        if (want.first) packets_out++;
        if (want.cut) cut_packets++;
      end
    end
  end

  // Watchdog on transaction activity.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: no transaction for %0d cycles, %0d packet words outstanding",
                 $time, idle_cycles, awaited_words.size());
        $display("word_stream_packet_delimiter: mismatch");
        $finish;
      end
    end
  end

  initial begin : run
    int unsigned      stream_goal;
    int unsigned      body;
    int unsigned      spot;
    logic [WordW-1:0] seq [8];

    in_if.valid      = 1'b0;
    in_if.data_word  = '0;
    in_if.stream_end = 1'b0;
    out_if.ready     = 1'b0;
    rst_ni           = 1'b0;
    mismatches  = 0;
    words_fed   = 0;
    words_out   = 0;
    packets_out = 0;
    cut_packets = 0;
    idle_cycles = 0;
    gap_left    = 0;
    burst_left  = 1;
    stall_pat   = '1;
    pat_pos     = 0;
    pat_left    = 24;
    restart_search();

    // Directed opener.
    // Extreme words while searching; stream end there just clears the window.
    add_word(16'h0000, 1'b0);
    add_word(16'hFFFF, 1'b1);
    // Long-header start whose own start word ends the stream: eighth word cut short.
    add_word(Marker,   1'b0);
    add_word(StartMid, 1'b0);
    add_word(Marker,   1'b1);
    // Short-header start built from the range edges.
    add_word(K1HdrLo, 1'b0);
    add_word(K1HdrHi, 1'b0);
    add_word(K1HdrLo, 1'b0);
    add_word(K1HdrHi, 1'b0);
    add_word(K1SubLo, 1'b0);
    add_word(K1SubHi, 1'b0);
    add_word(K1SubLo, 1'b0);
    add_word(16'h1234, 1'b0);
    // Immediate trailer at the range edges; its last word also ends the stream,
    // so the packet closes normally rather than cut short.
    add_word(K1TrlLo, 1'b0);
    add_word(K1TrlHi, 1'b0);
    add_word(K1TrlLo, 1'b0);
    add_word(K1TrlHi, 1'b0);
    add_word(K1EndLo, 1'b0);
    add_word(K1EndHi, 1'b0);
    add_word(K1EndLo, 1'b0);
    add_word(16'h0000, 1'b1);

    // Random part: mostly well-formed packets with random content, plus noise
    // and near-miss start patterns. A stray stream end may land anywhere.
    stream_goal = raw_stream.size() + RandomWords;
    while (raw_stream.size() < stream_goal) begin
      for (int i = $urandom_range(0, 2); i > 0; i--) add_word(16'($urandom), 1'b0);
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          // long-header packet
          add_word(Marker, 1'b0);
          add_word(StartMid, 1'b0);
          add_word(Marker, $urandom_range(0, 39) == 0);
          if ($urandom_range(0, 4) == 0) begin
            // trailer in the first header words: packet ends right at length 20
            add_word(Marker, 1'b0);
            add_word(Marker, 1'b0);
            add_word(AllOnes, 1'b0);
            add_word(Marker, 1'b0);
            for (int i = 0; i < 8; i++) add_word(16'($urandom), $urandom_range(0, 39) == 0);
          end else begin
            for (int i = 0; i < 12; i++) add_word(16'($urandom), $urandom_range(0, 39) == 0);
            body = $urandom_range(0, 8);
            for (int i = 0; i < body; i++) add_word(16'($urandom), $urandom_range(0, 39) == 0);
            add_word(Marker, 1'b0);
            add_word(Marker, 1'b0);
            add_word(AllOnes, 1'b0);
            add_word(Marker, 1'b0);
            for (int i = 0; i < 8; i++) add_word(16'($urandom), $urandom_range(0, 39) == 0);
          end
        end
        3, 4, 5: begin
          // short-header packet; now and then one trailer word is spoiled
          for (int i = 0; i < 4; i++) add_word(span_word(K1HdrLo, K1HdrHi), 1'b0);
          for (int i = 0; i < 3; i++) add_word(span_word(K1SubLo, K1SubHi), 1'b0);
          add_word(16'($urandom), $urandom_range(0, 39) == 0);
          body = $urandom_range(0, 6);
          for (int i = 0; i < body; i++) add_word(16'($urandom), $urandom_range(0, 39) == 0);
          for (int i = 0; i < 4; i++) seq[i] = span_word(K1TrlLo, K1TrlHi);
          for (int i = 4; i < 7; i++) seq[i] = span_word(K1EndLo, K1EndHi);
          seq[7] = 16'($urandom);
          if ($urandom_range(0, 3) == 0) begin
            spot = $urandom_range(0, 6);
            seq[spot] = (spot < 4) ? K1TrlLo - 16'd1 : K1EndHi + 16'd1;
          end
          for (int i = 0; i < 8; i++) add_word(seq[i], $urandom_range(0, 39) == 0);
        end
        6, 7: begin
          // noise, extremes included
          for (int i = $urandom_range(1, 8); i > 0; i--) begin
            case ($urandom_range(0, 5))
              0: add_word(16'h0000, $urandom_range(0, 14) == 0);
              1: add_word(16'hFFFF, $urandom_range(0, 14) == 0);
              default: add_word(16'($urandom), $urandom_range(0, 14) == 0);
            endcase
          end
        end
        default: begin
          // near-miss starts: one word just outside its range or one bit off
          if ($urandom_range(0, 1) == 0) begin
            for (int i = 0; i < 4; i++) seq[i] = span_word(K1HdrLo, K1HdrHi);
            for (int i = 4; i < 7; i++) seq[i] = span_word(K1SubLo, K1SubHi);
            seq[7] = 16'($urandom);
            spot = $urandom_range(0, 6);
            if (spot < 4) seq[spot] = $urandom_range(0, 1) ? K1HdrLo - 16'd1 : K1HdrHi + 16'd1;
            else seq[spot] = $urandom_range(0, 1) ? K1SubLo - 16'd1 : K1SubHi + 16'd1;
            for (int i = 0; i < 8; i++) add_word(seq[i], 1'b0);
          end else begin
            seq[0] = Marker;
            seq[1] = StartMid;
            seq[2] = Marker;
            spot = $urandom_range(0, 2);
            seq[spot] = seq[spot] ^ (16'h0001 << $urandom_range(0, 15));
            for (int i = 0; i < 3; i++) add_word(seq[i], 1'b0);
          end
        end
      endcase
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (raw_stream.size() != 0 || awaited_words.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Fed %0d raw words; checked %0d packet words in %0d packets, %0d cut short.",
             words_fed, words_out, packets_out, cut_packets);
    $display("Sender ran in bursts with gaps; receiver stalled on rotating ready patterns.");
    if (mismatches == 0 && awaited_words.size() == 0) begin
      $display("word_stream_packet_delimiter: match");
    end else begin
      $display("word_stream_packet_delimiter: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
rtl/core/wspd_pkg.sv
rtl/core/wspd_in_if.sv
rtl/core/wspd_out_if.sv
rtl/core/wspd_front.sv
rtl/core/wspd_queue.sv
rtl/core/wspd_back.sv
rtl/core/word_stream_packet_delimiter.sv
sim/word_stream_packet_delimiter_test.sv
